[hw/rtl/tpb_pkg.sv]
// shared types, constants and helpers for the tcp port blocklist table
package tpb_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PORT_W      = 16;

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        protocol;
        logic [PORT_W-1:0] port;
    } req_t;

    typedef struct packed {
        logic       blocked;
        logic       status;
        logic [4:0] entry_count;
    } rsp_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic              compare;
        logic              shift;
        logic              write;
        logic [PORT_W-1:0] key;
    } cell_cmd_t;

    // parallel-prefix or, bit i set when any bit at or below i is set
    function automatic logic [TABLE_DEPTH-1:0] prefix_or(input logic [TABLE_DEPTH-1:0] m);
        logic [TABLE_DEPTH-1:0] v;
        v = m;
        for (int s = 1; s < TABLE_DEPTH; s = s * 2)
        begin
            v = v | (v << s);
        end
        return v;
    endfunction

endpackage

[hw/rtl/tcp_port_blocklist_table.sv]
// tcp destination port blocklist table: sequencer and chain of table cells
//
//  channel   handshake        payload           direction
//  request   start / busy     request (req_t)   in
//  result    done strobe      result  (rsp_t)   out
//
// a request is taken at an edge with start high and busy low
// every request takes three cycles: capture, compare in all cells, then
// execute; the result strobe comes in the cycle after execute, when busy
// is already low again, so a new request may be taken every third cycle
// the cycle count is set by the registered per-cell match bits and the
// prefix or over them that picks the first match for a remove
// reset clears the fill count and the sequencer; cell contents stay
// undefined and are never read above the fill count
// done is high for exactly one cycle; the receiver cannot stall it
module tcp_port_blocklist_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tpb_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output tpb_pkg::rsp_t result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    tpb_pkg::req_t                   req_reg;
    tpb_pkg::req_t                   req_next;
    logic [tpb_pkg::CNT_W-1:0]       count_reg;
    logic [tpb_pkg::CNT_W-1:0]       count_next;
    logic                            done_reg;
    logic                            done_next;
    tpb_pkg::rsp_t                   result_reg;
    tpb_pkg::rsp_t                   result_next;

    // chain wiring
    logic [tpb_pkg::TABLE_DEPTH-1:0] match_vec;
    logic [tpb_pkg::TABLE_DEPTH-1:0] first_vec;
    logic [tpb_pkg::PORT_W-1:0]      entry_vec [tpb_pkg::TABLE_DEPTH];
    tpb_pkg::cell_cmd_t              cell_cmd  [tpb_pkg::TABLE_DEPTH];

    logic hit;
    logic full;
    logic exec_add;
    logic exec_remove;

    assign busy = state_reg != ST_IDLE;

    assign hit       = |match_vec;
    // cells from the first match upward take their upper neighbor
    assign first_vec = tpb_pkg::prefix_or(match_vec);
    assign full      = count_reg >= tpb_pkg::CNT_W'(tpb_pkg::TABLE_DEPTH);

    assign exec_add    = (state_reg == ST_EXEC) && (req_reg.command == tpb_pkg::CMD_ADD)
                         && !full;
    assign exec_remove = (state_reg == ST_EXEC) && (req_reg.command == tpb_pkg::CMD_REMOVE);

    genvar gi;
    generate
        for (gi = 0; gi < tpb_pkg::TABLE_DEPTH; gi++)
        begin : g_cell
            logic [tpb_pkg::PORT_W-1:0] upper;

            // top cell has no upper neighbor; what it takes lies past the count
            if (gi == tpb_pkg::TABLE_DEPTH - 1)
            begin : g_top
                assign upper = entry_vec[gi];
            end
            else
            begin : g_mid
                assign upper = entry_vec[gi + 1];
            end

            always_comb
            begin
                cell_cmd[gi].compare = state_reg == ST_CMP;
                cell_cmd[gi].shift   = exec_remove && first_vec[gi];
                cell_cmd[gi].write   = exec_add
                                       && (count_reg == tpb_pkg::CNT_W'(gi));
                cell_cmd[gi].key     = req_reg.port;
            end

            tpb_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cell_cmd[gi]),
                .index      (tpb_pkg::CNT_W'(gi)),
                .count      (count_reg),
                .next_entry (upper),
                .entry      (entry_vec[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_add)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (exec_remove && hit)
                begin
                    count_next = count_reg - 1'b1;
                end
                result_next.blocked     = (req_reg.command == tpb_pkg::CMD_LOOKUP)
                                          && (req_reg.protocol == tpb_pkg::TCP_PROTOCOL)
                                          && hit;
                result_next.status      = (req_reg.command == tpb_pkg::CMD_ADD) && full;
                result_next.entry_count = 5'(count_next);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hw/rtl/tpb_cell.sv]
// one table cell: a stored port, its compare and the shift from the next cell
module tpb_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tpb_pkg::cell_cmd_t                cmd,
    input  logic [tpb_pkg::CNT_W-1:0]         index,
    input  logic [tpb_pkg::CNT_W-1:0]         count,
    input  logic [tpb_pkg::PORT_W-1:0]        next_entry,
    output logic [tpb_pkg::PORT_W-1:0]        entry,
    output logic                              match
);

    logic [tpb_pkg::PORT_W-1:0] entry_reg;
    logic [tpb_pkg::PORT_W-1:0] entry_next;
    logic                       match_reg;
    logic                       match_next;
    logic                       valid;

    // entries at or above the fill count hold nothing
    assign valid = index < count;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.write)
        begin
            entry_next = cmd.key;
        end
        else if (cmd.shift)
        begin
            entry_next = next_entry;
        end
        match_next = cmd.compare ? (valid && (entry_reg == cmd.key)) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule
